// ===== hw/rtl/tksel_pkg.sv =====
package tksel_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_CLASSES_DEF = 1024;
   localparam int TOP_MAX_DEF     = 64;
   localparam int SCORE_BITS_DEF  = 16;

   // Field widths fixed by the interface
   localparam int TOPK_W     = 7;
   localparam int IDX_OUT_W  = 10;
   localparam int PROB_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOPK_W-1:0] TOPK_RESET = 7'd5;
   localparam logic [PROB_W-1:0] PROB_MAX   = 16'hFFFF;

   // Register word index (paddr[2])
   localparam logic REG_TOP_K = 1'b0;

   // Status of the normalizing divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hw/rtl/tksel_ram.sv =====
module tksel_ram #(
   parameter int WIDTH = tksel_pkg::SCORE_BITS_DEF,
   parameter int DEPTH = tksel_pkg::MAX_CLASSES_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/tksel_div.sv =====
module tksel_div #(
   parameter int SCORE_BITS = tksel_pkg::SCORE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SCORE_BITS-1:0]         off,
   input  logic [SCORE_BITS-1:0]         span,
   output tksel_pkg::div_stat_type       stat,
   output logic [tksel_pkg::PROB_W-1:0]  prob
);

   import tksel_pkg::*;

   localparam int STEP_W = $clog2(PROB_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SCORE_BITS-1:0] rem_ff, rem_in;
   logic [SCORE_BITS-1:0] span_ff, span_in;
   logic [PROB_W-1:0]     quo_ff, quo_in;
   logic                  zero_ff, zero_in;
   logic                  sat_ff, sat_in;

   logic [SCORE_BITS:0]   shifted;
   logic                  ge;

   // One quotient bit per cycle; remainder stays at or below span
   assign shifted = {rem_ff, 1'b0};
   assign ge      = shifted >= {1'b0, span_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = off;
         span_in = span;
         quo_in  = '0;
         zero_in = (span == '0);
         sat_in  = (off == span);
      end else if (busy_ff) begin
         rem_in  = ge ? SCORE_BITS'(shifted - {1'b0, span_ff}) : SCORE_BITS'(shifted);
         quo_in  = {quo_ff[PROB_W-2:0], ge};
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(PROB_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prob      = zero_ff ? '0 : (sat_ff ? PROB_MAX : quo_ff);

endmodule

// ===== hw/rtl/topk_score_select_minmax_norm.sv =====
// Channel  Direction  Handshake        Payload
// req      in         req_valid/stall  req_score, req_last
// rsp      out        rsp_valid/stall  rsp_class_index, rsp_probability, rsp_end_of_run
// csr      in/out     APB psel/penable csr_paddr, csr_pwdata, csr_prdata
//
// Scores load at one request per cycle into the score RAM while no run is active.
// After the request with last set, each result comes from one full read sweep of the score
// RAM, the bit-serial divider and the output register. Requests stall meanwhile.
// Reset is synchronous; it empties the set and sets top_k to 5. No clearing pass.
// The output register holds a result under rsp_stall; the next sweep runs meanwhile.
module topk_score_select_minmax_norm #(
   parameter int MAX_CLASSES = tksel_pkg::MAX_CLASSES_DEF,
   parameter int TOP_MAX     = tksel_pkg::TOP_MAX_DEF,
   parameter int SCORE_BITS  = tksel_pkg::SCORE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SCORE_BITS-1:0]          req_score,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tksel_pkg::IDX_OUT_W-1:0]       rsp_class_index,
   output logic [tksel_pkg::PROB_W-1:0]          rsp_probability,
   output logic                                  rsp_end_of_run,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tksel_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tksel_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tksel_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   import tksel_pkg::*;

   localparam int AW  = $clog2(MAX_CLASSES);
   localparam int CW  = $clog2(MAX_CLASSES + 1);
   localparam int KW  = (CW > TOPK_W) ? CW : TOPK_W;
   localparam int IXW = AW + IDX_OUT_W;
   localparam logic signed [SCORE_BITS-1:0] MOST_NEG = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [SCORE_BITS-1:0] MOST_POS = {1'b0, {(SCORE_BITS-1){1'b1}}};

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic signed [SCORE_BITS-1:0]  max_ff, max_in;
   logic signed [SCORE_BITS-1:0]  min_ff, min_in;
   logic [TOPK_W-1:0]             topk_ff, topk_in;
   logic [TOPK_W-1:0]             k_ff, k_in;
   logic [TOPK_W-1:0]             rank_ff, rank_in;
   logic [CW-1:0]                 addr_ff, addr_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [AW-1:0]                 rd_idx_ff, rd_idx_in;
   logic                          found_ff, found_in;
   logic signed [SCORE_BITS-1:0]  best_s_ff, best_s_in;
   logic [AW-1:0]                 best_i_ff, best_i_in;
   logic                          have_prev_ff, have_prev_in;
   logic signed [SCORE_BITS-1:0]  prev_s_ff, prev_s_in;
   logic [AW-1:0]                 prev_i_ff, prev_i_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]          cls_ff, cls_in;
   logic [PROB_W-1:0]             prob_ff, prob_in;
   logic                          eor_ff, eor_in;

   logic                          ram_we;
   logic [SCORE_BITS-1:0]         ram_rdata;
   logic signed [SCORE_BITS-1:0]  rd_s;
   logic                          store_ok;
   logic [CW-1:0]                 cnt_next;
   logic [KW-1:0]                 k_sel;
   logic                          eligible;
   logic                          scan_done;
   logic                          out_free;
   logic                          last_rank;
   logic                          div_start;
   logic [SCORE_BITS-1:0]         div_off;
   logic [SCORE_BITS-1:0]         div_span;
   div_stat_type                  div_stat;
   logic [PROB_W-1:0]             div_prob;
   logic [IXW-1:0]                best_i_ext;
   logic                          csr_wr;

   tksel_ram #(
      .WIDTH (SCORE_BITS),
      .DEPTH (MAX_CLASSES)
   ) u_score_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_score),
      .raddr (addr_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   tksel_div #(
      .SCORE_BITS (SCORE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .off   (div_off),
      .span  (div_span),
      .stat  (div_stat),
      .prob  (div_prob)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign store_ok  = (count_ff < CW'(MAX_CLASSES));
   assign cnt_next  = store_ok ? CW'(count_ff + 1'b1) : count_ff;
   assign rd_s      = $signed(ram_rdata);

   // Next candidate must rank strictly below the previous pick (score desc, index asc)
   assign eligible  = !have_prev_ff || (rd_s < prev_s_ff) ||
                      ((rd_s == prev_s_ff) && (rd_idx_ff > prev_i_ff));
   assign scan_done = (addr_ff == count_ff) && !rd_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_rank = (TOPK_W'(rank_ff + 1'b1) == k_ff);
   assign div_off   = SCORE_BITS'(best_s_ff - min_ff);
   assign div_span  = SCORE_BITS'(max_ff - min_ff);
   assign best_i_ext = IXW'(best_i_ff);

   always_comb begin
      k_sel = (topk_ff == '0) ? KW'(cnt_next) : KW'(topk_ff);
      if (k_sel > KW'(TOP_MAX)) begin
         k_sel = KW'(TOP_MAX);
      end
      if (k_sel > KW'(cnt_next)) begin
         k_sel = KW'(cnt_next);
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      topk_in = topk_ff;
      if (csr_wr && (csr_paddr[2] == REG_TOP_K)) begin
         topk_in = csr_pwdata[TOPK_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOP_K) ? CSR_DATA_W'(topk_ff) : '0;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      k_in         = k_ff;
      rank_in      = rank_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      best_s_in    = best_s_ff;
      best_i_in    = best_i_ff;
      have_prev_in = have_prev_ff;
      prev_s_in    = prev_s_ff;
      prev_i_in    = prev_i_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cls_in       = cls_ff;
      prob_in      = prob_ff;
      eor_in       = eor_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (store_ok) begin
                  ram_we   = 1'b1;
                  count_in = cnt_next;
                  if (req_score > max_ff) begin
                     max_in = req_score;
                  end
                  if (req_score < min_ff) begin
                     min_in = req_score;
                  end
               end
               if (req_last) begin
                  k_in         = TOPK_W'(k_sel);
                  rank_in      = '0;
                  addr_in      = '0;
                  found_in     = 1'b0;
                  have_prev_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff != count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[AW-1:0];
               addr_in   = CW'(addr_ff + 1'b1);
            end
            // Strict compare keeps the lower index on ties
            if (rd_vld_ff && eligible && (!found_ff || (rd_s > best_s_ff))) begin
               best_s_in = rd_s;
               best_i_in = rd_idx_ff;
               found_in  = 1'b1;
            end
            if (scan_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               cls_in       = best_i_ext[IDX_OUT_W-1:0];
               prob_in      = div_prob;
               eor_in       = last_rank;
               prev_s_in    = best_s_ff;
               prev_i_in    = best_i_ff;
               have_prev_in = 1'b1;
               rank_in      = TOPK_W'(rank_ff + 1'b1);
               if (last_rank) begin
                  // Drop the set and start the next load
                  count_in = '0;
                  max_in   = MOST_NEG;
                  min_in   = MOST_POS;
                  state_in = ST_LOAD;
               end else begin
                  addr_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         max_ff       <= MOST_NEG;
         min_ff       <= MOST_POS;
         topk_ff      <= TOPK_RESET;
         k_ff         <= '0;
         rank_ff      <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         topk_ff      <= topk_in;
         k_ff         <= k_in;
         rank_ff      <= rank_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      best_s_ff <= best_s_in;
      best_i_ff <= best_i_in;
      prev_s_ff <= prev_s_in;
      prev_i_ff <= prev_i_in;
      cls_ff    <= cls_in;
      prob_ff   <= prob_in;
      eor_ff    <= eor_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = cls_ff;
   assign rsp_probability = prob_ff;
   assign rsp_end_of_run  = eor_ff;

   a_rank_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (rank_ff < k_ff))
      else $error("rank reached k during a run");

   a_k_fits_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> ((k_ff != '0) && (KW'(k_ff) <= KW'(count_ff))))
      else $error("k outside 1..score count");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (max_ff >= min_ff))
      else $error("running max below running min");

   a_sweep_finds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && scan_done) |-> found_ff)
      else $error("read sweep ended without a candidate");

   a_read_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("score read outside a sweep");

endmodule

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tksel_pkg::*;

   localparam int N_RANDOM  = 370;
   localparam int IDLE_WAIT = 40;

   localparam logic [CSR_ADDR_W-1:0] TOPK_ADDR  = {1'b0, REG_TOP_K, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   typedef enum int {SPREAD_WIDE, SPREAD_TIES, SPREAD_FLAT, SPREAD_RAILS} spread_type;

   typedef struct packed {
      logic signed [SCORE_BITS_DEF-1:0] score;
      logic                             last;
   } score_item_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] class_idx;
      logic [PROB_W-1:0]    prob;
      logic                 run_end;
   } ranked_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic signed [SCORE_BITS_DEF-1:0] req_score = '0;
   logic                             req_last  = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [IDX_OUT_W-1:0]             rsp_class_index;
   logic [PROB_W-1:0]                rsp_probability;
   logic                             rsp_end_of_run;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]            csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]            csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]            csr_prdata;
   logic                             csr_pready;

   // stimulus and expected ranking
   score_item_type    score_q[$];
   ranked_result_type ranked_q[$];
   score_item_type    next_item;
   ranked_result_type want;

   // shadow of the set being loaded
   logic signed [SCORE_BITS_DEF-1:0] set_scores [MAX_CLASSES_DEF];
   bit                               picked     [MAX_CLASSES_DEF];
   int unsigned                      set_count = 0;
   logic signed [SCORE_BITS_DEF-1:0] set_hi = 16'sh8000;
   logic signed [SCORE_BITS_DEF-1:0] set_lo = 16'sh7FFF;
   logic [TOPK_W-1:0]                topk_shadow = TOPK_RESET;

   int n_req = 0, n_rsp = 0, n_sets = 0, n_queued = 0, errors = 0;
   int req_gap = 0, req_calm = 0;
   int stall_left = 0, rsp_calm = 0, hold_left = 0, hold_span = 0;
   bit hold_armed = 1'b0;

   topk_score_select_minmax_norm u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_score       (req_score),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_class_index (rsp_class_index),
      .rsp_probability (rsp_probability),
      .rsp_end_of_run  (rsp_end_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [SCORE_BITS_DEF-1:0] draw_score(
      input spread_type flavor, input logic signed [SCORE_BITS_DEF-1:0] anchor);
      logic [31:0] raw;
      raw = $urandom;
      case (flavor)
         SPREAD_TIES:  return anchor + $signed({13'd0, raw[2:0]}) - 16'sd3;
         SPREAD_FLAT:  return anchor;
         SPREAD_RAILS: begin
            case (raw[18:16])
               3'd0, 3'd1: return 16'sh8000;
               3'd2, 3'd3: return 16'sh7FFF;
               3'd4:       return 16'sh0000;
               3'd5:       return -16'sd1;
               default:    return raw[15:0];
            endcase
         end
         default:      return raw[15:0];
      endcase
   endfunction

   // Rank the set on its last score: k highest, descending, lower index on ties.
   task automatic rank_set(input logic signed [SCORE_BITS_DEF-1:0] s, input logic lst);
      int unsigned       k;
      int                best;
      longint            span, off, p;
      ranked_result_type res;
      if (set_count < MAX_CLASSES_DEF) begin
         set_scores[set_count] = s;
         set_count++;
         if (s > set_hi) set_hi = s;
         if (s < set_lo) set_lo = s;
      end
      if (!lst) return;
      k = (topk_shadow == 0) ? set_count : topk_shadow;
      if (k > TOP_MAX_DEF) k = TOP_MAX_DEF;
      if (k > set_count) k = set_count;
      span = (set_hi >= set_lo) ? longint'(set_hi) - longint'(set_lo) : 0;
      for (int unsigned r = 0; r < k; r++) begin
         best = -1;
         for (int unsigned i = 0; i < set_count; i++) begin
            if (!picked[i] && (best < 0 || set_scores[i] > set_scores[best]))
               best = i;
         end
         picked[best] = 1'b1;
         p = 0;
         if (span != 0) begin
            off = longint'(set_scores[best]) - longint'(set_lo);
            p = (off << 16) / span;
            if (p > longint'(PROB_MAX)) p = longint'(PROB_MAX);
         end
         res.class_idx = best[IDX_OUT_W-1:0];
         res.prob      = p[PROB_W-1:0];
         res.run_end   = (r + 1 == k);
         ranked_q.push_back(res);
      end
      for (int unsigned i = 0; i < set_count; i++) picked[i] = 1'b0;
      set_count = 0;
      set_hi = 16'sh8000;
      set_lo = 16'sh7FFF;
   endtask

   // request driver: payload holds while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (req_calm > 0) req_calm--;
         else if ($urandom_range(0, 199) == 0) req_calm = $urandom_range(40, 200);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (score_q.size() != 0) begin
            next_item = score_q.pop_front();
            req_valid <= 1'b1;
            req_score <= next_item.score;
            req_last  <= next_item.last;
            req_gap = (req_calm > 0) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed && rsp_valid) begin
            hold_armed = 1'b0;
            hold_left  = hold_span;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_calm > 0) begin
            rsp_calm--;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 299) == 0) rsp_calm = $urandom_range(50, 300);
            else if ($urandom_range(0, 99) < 35) stall_left = pick_gap();
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n_req++;
            rank_set(req_score, req_last);
         end
         if (rsp_valid && !rsp_stall) begin
            n_rsp++;
            if (ranked_q.size() == 0) begin
               errors++;
               $display("%0t: expected no result, actual idx=%0d prob=%0d end=%0b",
                        $time, rsp_class_index, rsp_probability, rsp_end_of_run);
            end else begin
               want = ranked_q.pop_front();
               if (rsp_class_index !== want.class_idx) begin
                  errors++;
                  $display("%0t: class_index expected %0d actual %0d",
                           $time, want.class_idx, rsp_class_index);
               end
               if (rsp_probability !== want.prob) begin
                  errors++;
                  $display("%0t: probability expected %0d actual %0d",
                           $time, want.prob, rsp_probability);
               end
               if (rsp_end_of_run !== want.run_end) begin
                  errors++;
                  $display("%0t: end_of_run expected %0b actual %0b",
                           $time, want.run_end, rsp_end_of_run);
               end
            end
         end
      end
   end

   task automatic push_score(input logic signed [SCORE_BITS_DEF-1:0] s, input logic lst);
      score_item_type it;
      it.score = s;
      it.last  = lst;
      score_q.push_back(it);
      if (lst) n_sets++;
   endtask

   task automatic push_set(input int unsigned n, input spread_type flavor);
      logic [31:0] raw;
      logic signed [SCORE_BITS_DEF-1:0] anchor;
      raw = $urandom;
      anchor = raw[15:0];
      for (int unsigned i = 0; i < n; i++)
         push_score(draw_score(flavor, anchor), i == n - 1);
   endtask

   // Hold until the block has drained every request and result.
   task automatic settle_idle();
      do @(posedge clock);
      while (score_q.size() != 0 || req_valid || ranked_q.size() != 0);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == TOPK_ADDR) topk_shadow = data[TOPK_W-1:0];
   endtask

   task automatic new_top_k();
      case ($urandom_range(0, 5))
         0:       write_reg(TOPK_ADDR, 0);
         1:       write_reg(TOPK_ADDR, 1);
         2:       write_reg(TOPK_ADDR, TOP_MAX_DEF);
         3:       write_reg(TOPK_ADDR, $urandom_range(TOP_MAX_DEF + 1, 127));
         default: write_reg(TOPK_ADDR, $urandom_range(2, 20));
      endcase
   endtask

   initial begin
      int         r, n;
      spread_type flavor;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset top_k: rails and full span, lone score, flat set
      push_score(16'sh7FFF, 1'b0);
      push_score(16'sh8000, 1'b0);
      push_score(16'sh0000, 1'b0);
      push_score(16'sh0100, 1'b0);
      push_score(-16'sd1,   1'b1);
      push_score(-16'sd200, 1'b1);
      repeat (3) push_score(16'sd100, 1'b0);
      push_score(16'sd100, 1'b1);
      settle_idle();
      // all scores, with ties
      write_reg(TOPK_ADDR, 0);
      push_score(16'sd5, 1'b0);
      push_score(-16'sd3, 1'b0);
      push_score(16'sd5, 1'b0);
      push_score(16'sd7, 1'b0);
      push_score(-16'sd3, 1'b0);
      push_score(16'sd7, 1'b1);
      settle_idle();
      write_reg(TOPK_ADDR, 1);
      push_score(-16'sd5, 1'b0);
      push_score(-16'sd5, 1'b0);
      push_score(-16'sd9, 1'b1);
      settle_idle();
      // unmapped register: top_k must stay at one
      write_reg(SPARE_ADDR, 2);
      push_score(16'sd1, 1'b0);
      push_score(16'sd2, 1'b1);
      settle_idle();
      write_reg(TOPK_ADDR, 127);
      push_score(-16'sd1, 1'b0);
      push_score(16'sh7FFF, 1'b0);
      push_score(16'sh8000, 1'b1);
      settle_idle();

      // back-pressure: hold results while further sets queue behind
      write_reg(TOPK_ADDR, 4);
      hold_span  = 600;
      hold_armed = 1'b1;
      push_set(8, SPREAD_WIDE);
      push_set(5, SPREAD_TIES);
      push_set(10, SPREAD_WIDE);
      settle_idle();

      while (n_queued < N_RANDOM) begin
         r = $urandom_range(0, 99);
         if (r < 60) n = $urandom_range(1, 12);
         else if (r < 90) n = $urandom_range(13, 40);
         else if (r < 98) n = $urandom_range(41, 100);
         else n = $urandom_range(101, 200);
         if (n > N_RANDOM - n_queued) n = N_RANDOM - n_queued;
         r = $urandom_range(0, 99);
         if (r < 55) flavor = SPREAD_WIDE;
         else if (r < 75) flavor = SPREAD_TIES;
         else if (r < 85) flavor = SPREAD_FLAT;
         else flavor = SPREAD_RAILS;
         if ($urandom_range(0, 3) == 0) begin
            settle_idle();
            new_top_k();
         end
         push_set(n, flavor);
         n_queued += n;
      end
      settle_idle();

      $display("Covered %0d score requests in %0d sets and %0d ranked results,", n_req, n_sets,
               n_rsp);
      $display("top_k 0..127, flat, tied and rail sets, long result hold-off.");
      if (errors == 0 && ranked_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d results outstanding", ranked_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/tksel_pkg.sv
hw/rtl/tksel_ram.sv
hw/rtl/tksel_div.sv
hw/rtl/topk_score_select_minmax_norm.sv
bench/tb.sv
